### rtl/vfa_pkg.sv
// Shared types, opcodes and helpers for the Q16.16 three-component vector ALU.
package vfa_pkg;

   localparam logic [3:0] FN_ADD    = 4'd0;
   localparam logic [3:0] FN_SUB    = 4'd1;
   localparam logic [3:0] FN_NEG    = 4'd2;
   localparam logic [3:0] FN_SCALE  = 4'd3;
   localparam logic [3:0] FN_DIV    = 4'd4;
   localparam logic [3:0] FN_DOT    = 4'd5;
   localparam logic [3:0] FN_CROSS  = 4'd6;
   localparam logic [3:0] FN_MAGSQ  = 4'd7;
   localparam logic [3:0] FN_MAG    = 4'd8;
   localparam logic [3:0] FN_NORM   = 4'd9;
   localparam logic [3:0] FN_DIST   = 4'd10;
   localparam logic [3:0] FN_DISTSQ = 4'd11;
   localparam logic [3:0] FN_CLOSE  = 4'd12;
   localparam logic [3:0] FN_LESS   = 4'd13;
   localparam logic [3:0] FN_EQUAL  = 4'd14;
   // spare opcode, all outputs zero
   localparam logic [3:0] FN_NONE   = 4'd15;

   localparam int ROOT_STAGES  = 32;
   localparam int RECIP_STAGES = 33;

   localparam logic [30:0] TOL_RESET = 31'd655;
   localparam logic [1:0]  ADDR_TOL  = 2'd0;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [3:0]         func;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] bz;
      logic signed [31:0] scale_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [31:0] rz;
      logic signed [31:0] scalar_result;
      logic               compare_flag;
      logic               overflow_flag;
   } rsp_type;

   // floored products and squares from one lane
   typedef struct packed {
      logic signed [47:0] scl_f;
      logic signed [47:0] dot_f;
      logic signed [47:0] c1_f;
      logic signed [47:0] c2_f;
      logic [49:0]        sq_f;
      logic signed [32:0] dif;
   } lane_type;

   typedef struct packed {
      logic [2:0][31:0] r;
      logic [31:0]      sc;
      logic             cmp;
      logic             ov;
      logic             big;
      logic             zero;
   } mrg_type;

   typedef struct packed {
      logic [3:0]       func;
      logic [2:0][31:0] a;
      logic [31:0]      s;
      mrg_type          mrg;
   } ctx_type;

   typedef struct packed {
      ctx_type     ctx;
      logic [31:0] root;
   } ctx2_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic               ov;
   } sat_type;

   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type res;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         res.val = S32_MAX;
         res.ov  = 1'b1;
      end else if (v < 64'shFFFF_FFFF_8000_0000) begin
         res.val = S32_MIN;
         res.ov  = 1'b1;
      end else begin
         res.val = v[31:0];
         res.ov  = 1'b0;
      end
      return res;
   endfunction

endpackage

### rtl/vfa_lane.sv
// One component lane: products and squares for one vector element, registered.
module vfa_lane (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   input  logic signed [31:0] a_n1,
   input  logic signed [31:0] b_n1,
   input  logic signed [31:0] a_n2,
   input  logic signed [31:0] b_n2,
   input  logic signed [31:0] scl,
   input  logic               use_dif,
   output vfa_pkg::lane_type  lane_out
);

   logic signed [63:0] p_scl_in, p_scl_ff;
   logic signed [63:0] p_dot_in, p_dot_ff;
   logic signed [63:0] p_c1_in, p_c1_ff;
   logic signed [63:0] p_c2_in, p_c2_ff;
   logic [65:0]        sq_in, sq_ff;
   logic signed [32:0] dif_in, dif_ff;
   logic signed [32:0] base;
   logic [32:0]        mag;

   assign dif_in   = 33'(a) - 33'(b);
   assign base     = use_dif ? dif_in : 33'(a);
   assign mag      = base[32] ? (~base + 33'd1) : base;
   assign p_scl_in = a * scl;
   assign p_dot_in = a * b;
   assign p_c1_in  = a_n1 * b_n2;
   assign p_c2_in  = b_n1 * a_n2;
   assign sq_in    = 66'(mag) * 66'(mag);

   always_ff @(posedge clock) begin
      if (en) begin
         p_scl_ff <= p_scl_in;
         p_dot_ff <= p_dot_in;
         p_c1_ff  <= p_c1_in;
         p_c2_ff  <= p_c2_in;
         sq_ff    <= sq_in;
         dif_ff   <= dif_in;
      end
   end

   // dropping the low 16 bits of a two's complement product floors it
   assign lane_out.scl_f = p_scl_ff[63:16];
   assign lane_out.dot_f = p_dot_ff[63:16];
   assign lane_out.c1_f  = p_c1_ff[63:16];
   assign lane_out.c2_f  = p_c2_ff[63:16];
   assign lane_out.sq_f  = sq_ff[65:16];
   assign lane_out.dif   = dif_ff;

endmodule

### rtl/vfa_merge.sv
// Merge stage: combines lane results into vector, scalar and compare outcomes.
module vfa_merge (
   input  logic                    clock,
   input  logic                    en,
   input  vfa_pkg::req_type        req,
   input  vfa_pkg::lane_type [2:0] lane_out,
   input  logic [30:0]             tol,
   output vfa_pkg::ctx_type        ctx,
   output logic [63:0]             rad
);

   logic signed [31:0] a [3];
   logic signed [31:0] b [3];
   vfa_pkg::sat_type   s_add [3];
   vfa_pkg::sat_type   s_sub [3];
   vfa_pkg::sat_type   s_neg [3];
   vfa_pkg::sat_type   s_scl [3];
   vfa_pkg::sat_type   s_crs [3];
   vfa_pkg::sat_type   s_dot;
   logic [32:0]        adif [3];
   logic [2:0]         near, lt, eq;
   logic signed [63:0] dot_sum;
   logic [50:0]        sq_sum;
   vfa_pkg::mrg_type   mrg;
   vfa_pkg::ctx_type   ctx_in, ctx_ff;
   logic [63:0]        rad_in, rad_ff;

   assign a[0] = req.ax;
   assign a[1] = req.ay;
   assign a[2] = req.az;
   assign b[0] = req.bx;
   assign b[1] = req.by;
   assign b[2] = req.bz;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s_add[i] = vfa_pkg::sat32(64'(a[i]) + 64'(b[i]));
         s_sub[i] = vfa_pkg::sat32(64'(a[i]) - 64'(b[i]));
         s_neg[i] = vfa_pkg::sat32(-64'(a[i]));
         s_scl[i] = vfa_pkg::sat32(64'(lane_out[i].scl_f));
         s_crs[i] = vfa_pkg::sat32(64'(lane_out[i].c1_f) - 64'(lane_out[i].c2_f));
         adif[i]  = lane_out[i].dif[32] ? (~lane_out[i].dif + 33'd1) : lane_out[i].dif;
         near[i]  = adif[i] <= {2'b00, tol};
         lt[i]    = a[i] < b[i];
         eq[i]    = a[i] == b[i];
      end
      dot_sum = 64'(lane_out[0].dot_f) + 64'(lane_out[1].dot_f) + 64'(lane_out[2].dot_f);
      s_dot   = vfa_pkg::sat32(dot_sum);
      sq_sum  = 51'(lane_out[0].sq_f) + 51'(lane_out[1].sq_f) + 51'(lane_out[2].sq_f);

      mrg      = '0;
      mrg.big  = sq_sum[50:46] != 5'd0;
      mrg.zero = sq_sum == 51'd0;
      case (req.func)
         vfa_pkg::FN_ADD: begin
            for (int i = 0; i < 3; i++) mrg.r[i] = s_add[i].val;
            mrg.ov = s_add[0].ov | s_add[1].ov | s_add[2].ov;
         end
         vfa_pkg::FN_SUB: begin
            for (int i = 0; i < 3; i++) mrg.r[i] = s_sub[i].val;
            mrg.ov = s_sub[0].ov | s_sub[1].ov | s_sub[2].ov;
         end
         vfa_pkg::FN_NEG: begin
            for (int i = 0; i < 3; i++) mrg.r[i] = s_neg[i].val;
            mrg.ov = s_neg[0].ov | s_neg[1].ov | s_neg[2].ov;
         end
         vfa_pkg::FN_SCALE: begin
            for (int i = 0; i < 3; i++) mrg.r[i] = s_scl[i].val;
            mrg.ov = s_scl[0].ov | s_scl[1].ov | s_scl[2].ov;
         end
         vfa_pkg::FN_DOT: begin
            mrg.sc = s_dot.val;
            mrg.ov = s_dot.ov;
         end
         vfa_pkg::FN_CROSS: begin
            for (int i = 0; i < 3; i++) mrg.r[i] = s_crs[i].val;
            mrg.ov = s_crs[0].ov | s_crs[1].ov | s_crs[2].ov;
         end
         vfa_pkg::FN_MAGSQ, vfa_pkg::FN_DISTSQ: begin
            if (sq_sum > 51'h0_7FFF_FFFF) begin
               mrg.sc = vfa_pkg::S32_MAX;
               mrg.ov = 1'b1;
            end else begin
               mrg.sc = sq_sum[31:0];
            end
         end
         vfa_pkg::FN_CLOSE: mrg.cmp = &near;
         vfa_pkg::FN_LESS:  mrg.cmp = &lt;
         vfa_pkg::FN_EQUAL: mrg.cmp = &eq;
         default: ;
      endcase
   end

   assign ctx_in.func = req.func;
   assign ctx_in.a[0] = req.ax;
   assign ctx_in.a[1] = req.ay;
   assign ctx_in.a[2] = req.az;
   assign ctx_in.s    = req.scale_value;
   assign ctx_in.mrg  = mrg;
   // radicand only matters when the square length is small enough to root
   assign rad_in      = {sq_sum[47:0], 16'h0000};

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_ff <= ctx_in;
         rad_ff <= rad_in;
      end
   end

   assign ctx = ctx_ff;
   assign rad = rad_ff;

endmodule

### rtl/vfa_root.sv
// Pipelined integer square root, two radicand bits per stage.
module vfa_root #(
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              en,
   input  logic [63:0]       rad,
   input  logic [SIDE_W-1:0] side_in,
   output logic [31:0]       root,
   output logic [SIDE_W-1:0] side_out
);

   localparam int N = vfa_pkg::ROOT_STAGES;

   logic [63:0]       rad_ff  [N];
   logic [33:0]       rem_ff  [N];
   logic [31:0]       root_ff [N];
   logic [SIDE_W-1:0] side_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [63:0]       rad_cur;
      logic [33:0]       rem_cur;
      logic [31:0]       root_cur;
      logic [SIDE_W-1:0] side_cur;
      logic [33:0]       rem_sh;
      logic [33:0]       trial;

      if (k == 0) begin : g_head
         assign rad_cur  = rad;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign side_cur = side_in;
      end else begin : g_body
         assign rad_cur  = rad_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      // remainder entering a stage stays below 2^32
      assign rem_sh = {rem_cur[31:0], rad_cur[63:62]};
      assign trial  = {root_cur, 2'b01};

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= {rad_cur[61:0], 2'b00};
            side_ff[k] <= side_cur;
            if (rem_sh >= trial) begin
               rem_ff[k]  <= rem_sh - trial;
               root_ff[k] <= {root_cur[30:0], 1'b1};
            end else begin
               rem_ff[k]  <= rem_sh;
               root_ff[k] <= {root_cur[30:0], 1'b0};
            end
         end
      end
   end

   assign root     = root_ff[N-1];
   assign side_out = side_ff[N-1];

endmodule

### rtl/vfa_recip.sv
// Pipelined restoring divider forming floor(2^32 / d), one quotient bit per stage.
module vfa_recip #(
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              en,
   input  logic [31:0]       d,
   input  logic [SIDE_W-1:0] side_in,
   output logic [32:0]       q,
   output logic [SIDE_W-1:0] side_out
);

   localparam int N = vfa_pkg::RECIP_STAGES;

   logic [31:0]       rem_ff  [N];
   logic [31:0]       d_ff    [N];
   logic [32:0]       q_ff    [N];
   logic [SIDE_W-1:0] side_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      // the numerator is a single one in its top bit
      localparam logic NUM_BIT = (k == 0) ? 1'b1 : 1'b0;
      logic [31:0]       rem_cur;
      logic [31:0]       d_cur;
      logic [32:0]       q_cur;
      logic [SIDE_W-1:0] side_cur;
      logic [32:0]       rem_sh;
      logic [32:0]       rem_sub;

      if (k == 0) begin : g_head
         assign rem_cur  = '0;
         assign d_cur    = d;
         assign q_cur    = '0;
         assign side_cur = side_in;
      end else begin : g_body
         assign rem_cur  = rem_ff[k-1];
         assign d_cur    = d_ff[k-1];
         assign q_cur    = q_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      assign rem_sh  = {rem_cur, NUM_BIT};
      assign rem_sub = rem_sh - {1'b0, d_cur};

      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[k]    <= d_cur;
            side_ff[k] <= side_cur;
            if (rem_sh >= {1'b0, d_cur}) begin
               rem_ff[k] <= rem_sub[31:0];
               q_ff[k]   <= {q_cur[31:0], 1'b1};
            end else begin
               rem_ff[k] <= rem_sh[31:0];
               q_ff[k]   <= {q_cur[31:0], 1'b0};
            end
         end
      end
   end

   assign q        = q_ff[N-1];
   assign side_out = side_ff[N-1];

endmodule

### rtl/vec3_fixed_point_alu.sv
// Top level of the Q16.16 three-component vector ALU pipeline.
//
// Requests arrive on req_valid/req_ready with a vfa_pkg::req_type payload
// (opcode, vectors A and B, scalar). Each request yields exactly one
// response on rsp_valid/rsp_ready carrying a vfa_pkg::rsp_type.
// Every opcode runs the same pipeline: one lane stage of three
// parallel multiplier lanes, one merge stage, 32 square root stages,
// 33 reciprocal stages, a scaling multiply stage and the output register.
// Throughput is one request per cycle unless the output stalls; pipeline
// depth is set by the digit-serial, fully unrolled root and reciprocal units.
// When the output register holds an untaken response the whole pipeline
// freezes and req_ready drops; it resumes the cycle rsp_ready is high.
// Reset empties the pipeline and sets the closeness tolerance to 655.
// The tolerance register sits at APB address 0 and should be written only
// while no request is in flight.
module vec3_fixed_point_alu (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vfa_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vfa_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [1:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int LAT = 4 + vfa_pkg::ROOT_STAGES + vfa_pkg::RECIP_STAGES;
   localparam int CTX_W  = $bits(vfa_pkg::ctx_type);
   localparam int CTX2_W = $bits(vfa_pkg::ctx2_type);

   logic                    pipe_en;
   logic [LAT-1:0]          vld_ff, vld_in;
   logic [30:0]             tol_ff, tol_in;
   vfa_pkg::req_type        req1_ff;
   vfa_pkg::lane_type [2:0] lane_out;
   logic signed [31:0]      a_arr [3];
   logic signed [31:0]      b_arr [3];
   vfa_pkg::ctx_type        ctx_m, ctx_r;
   logic [63:0]             rad;
   logic [31:0]             root;
   logic [CTX_W-1:0]        side_r;
   logic [31:0]             div_d;
   vfa_pkg::ctx2_type       ctx2_in, ctx2_q;
   logic [CTX2_W-1:0]       side_q;
   logic [32:0]             q;
   logic [31:0]             rc;
   logic                    rc_ov;
   logic                    s_neg;
   logic [31:0]             s_mag;
   logic signed [63:0]      prod_in [3];
   logic signed [63:0]      prod_ff [3];
   vfa_pkg::ctx2_type       ctx3_ff;
   logic                    rcov_ff;
   vfa_pkg::sat_type        s_fin [3];
   vfa_pkg::rsp_type        out_in, out_ff;
   logic signed [31:0]      a_fin;
   logic                    s_zero;

   // the pipeline moves whenever the output slot is free or being drained
   assign pipe_en   = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = pipe_en;
   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_data  = out_ff;

   assign vld_in = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         tol_ff <= vfa_pkg::TOL_RESET;
      end else begin
         if (pipe_en) vld_ff <= vld_in;
         tol_ff <= tol_in;
      end
   end

   // configuration port
   assign pready = 1'b1;
   assign tol_in = (psel && penable && pwrite && paddr == vfa_pkg::ADDR_TOL)
                   ? pwdata[30:0] : tol_ff;
   assign prdata = (paddr == vfa_pkg::ADDR_TOL) ? {1'b0, tol_ff} : 32'd0;

   // lane stage
   assign a_arr[0] = req_data.ax;
   assign a_arr[1] = req_data.ay;
   assign a_arr[2] = req_data.az;
   assign b_arr[0] = req_data.bx;
   assign b_arr[1] = req_data.by;
   assign b_arr[2] = req_data.bz;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      localparam int N1 = (i + 1) % 3;
      localparam int N2 = (i + 2) % 3;
      vfa_lane u_lane (
         .clock    (clock),
         .en       (pipe_en),
         .a        (a_arr[i]),
         .b        (b_arr[i]),
         .a_n1     (a_arr[N1]),
         .b_n1     (b_arr[N1]),
         .a_n2     (a_arr[N2]),
         .b_n2     (b_arr[N2]),
         .scl      (req_data.scale_value),
         .use_dif  (req_data.func == vfa_pkg::FN_DIST ||
                    req_data.func == vfa_pkg::FN_DISTSQ),
         .lane_out (lane_out[i])
      );
   end

   always_ff @(posedge clock) begin
      if (pipe_en) req1_ff <= req_data;
   end

   vfa_merge u_merge (
      .clock    (clock),
      .en       (pipe_en),
      .req      (req1_ff),
      .lane_out (lane_out),
      .tol      (tol_ff),
      .ctx      (ctx_m),
      .rad      (rad)
   );

   vfa_root #(.SIDE_W(CTX_W)) u_root (
      .clock    (clock),
      .en       (pipe_en),
      .rad      (rad),
      .side_in  (ctx_m),
      .root     (root),
      .side_out (side_r)
   );

   assign ctx_r        = vfa_pkg::ctx_type'(side_r);
   assign s_neg        = ctx_r.s[31];
   assign s_mag        = s_neg ? (~ctx_r.s + 32'd1) : ctx_r.s;
   assign div_d        = (ctx_r.func == vfa_pkg::FN_DIV) ? s_mag : root;
   assign ctx2_in.ctx  = ctx_r;
   assign ctx2_in.root = root;

   vfa_recip #(.SIDE_W(CTX2_W)) u_recip (
      .clock    (clock),
      .en       (pipe_en),
      .d        (div_d),
      .side_in  (ctx2_in),
      .q        (q),
      .side_out (side_q)
   );

   assign ctx2_q = vfa_pkg::ctx2_type'(side_q);

   // signed, saturated reciprocal
   always_comb begin
      rc    = q[31:0];
      rc_ov = 1'b0;
      if (ctx2_q.ctx.func == vfa_pkg::FN_DIV && ctx2_q.ctx.s != 32'd0) begin
         if (!ctx2_q.ctx.s[31]) begin
            if (q > 33'h0_7FFF_FFFF) begin
               rc    = vfa_pkg::S32_MAX;
               rc_ov = 1'b1;
            end
         end else begin
            if (q > 33'h0_8000_0000) begin
               rc    = vfa_pkg::S32_MIN;
               rc_ov = 1'b1;
            end else begin
               rc = 32'(~q + 33'd1);
            end
         end
      end
      for (int i = 0; i < 3; i++) prod_in[i] = $signed(ctx2_q.ctx.a[i]) * $signed(rc);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int i = 0; i < 3; i++) prod_ff[i] <= prod_in[i];
         ctx3_ff <= ctx2_q;
         rcov_ff <= rc_ov;
      end
   end

   // final select
   always_comb begin
      a_fin  = '0;
      s_zero = ctx3_ff.ctx.s == 32'd0;
      for (int i = 0; i < 3; i++)
         s_fin[i] = vfa_pkg::sat32(64'($signed(prod_ff[i][63:16])));
      out_in.rx            = ctx3_ff.ctx.mrg.r[0];
      out_in.ry            = ctx3_ff.ctx.mrg.r[1];
      out_in.rz            = ctx3_ff.ctx.mrg.r[2];
      out_in.scalar_result = ctx3_ff.ctx.mrg.sc;
      out_in.compare_flag  = ctx3_ff.ctx.mrg.cmp;
      out_in.overflow_flag = ctx3_ff.ctx.mrg.ov;
      case (ctx3_ff.ctx.func)
         vfa_pkg::FN_DIV: begin
            if (s_zero) begin
               // divide by zero: sign of each component picks the rail
               out_in.overflow_flag = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  a_fin = ctx3_ff.ctx.a[i];
                  s_fin[i].val = (a_fin > 0) ? vfa_pkg::S32_MAX :
                                 ((a_fin < 0) ? vfa_pkg::S32_MIN : 32'sd0);
               end
            end else begin
               out_in.overflow_flag = rcov_ff | s_fin[0].ov | s_fin[1].ov | s_fin[2].ov;
            end
            out_in.rx = s_fin[0].val;
            out_in.ry = s_fin[1].val;
            out_in.rz = s_fin[2].val;
         end
         vfa_pkg::FN_NORM: begin
            if (ctx3_ff.ctx.mrg.zero) begin
               out_in.rx = ctx3_ff.ctx.a[0];
               out_in.ry = ctx3_ff.ctx.a[1];
               out_in.rz = ctx3_ff.ctx.a[2];
               out_in.overflow_flag = 1'b0;
            end else begin
               out_in.rx = s_fin[0].val;
               out_in.ry = s_fin[1].val;
               out_in.rz = s_fin[2].val;
               out_in.overflow_flag = s_fin[0].ov | s_fin[1].ov | s_fin[2].ov;
            end
         end
         vfa_pkg::FN_MAG, vfa_pkg::FN_DIST: begin
            out_in.scalar_result = ctx3_ff.ctx.mrg.big ? vfa_pkg::S32_MAX : ctx3_ff.root;
            out_in.overflow_flag = ctx3_ff.ctx.mrg.big;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pipe_en) out_ff <= out_in;
   end

   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.compare_flag |->
         !rsp_data.overflow_flag && rsp_data.rx == 0 && rsp_data.ry == 0 &&
         rsp_data.rz == 0 && rsp_data.scalar_result == 0)
      else $error("compare response carries nonzero data");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted request missing from first stage");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> vld_ff == $past(vld_ff))
      else $error("pipeline moved while stalled");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output slot blocked");

endmodule

### tb/vec3_fixed_point_alu_check.sv
`timescale 1ns / 100ps
// Result checker for the vector ALU: predicts each response and compares it.
module vec3_fixed_point_alu_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  vfa_pkg::req_type  req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  vfa_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [1:0]        paddr,
   input  logic [31:0]       pwdata,
   input  logic              pready,
   output int                mismatches,
   output int                in_flight
);

   vfa_pkg::rsp_type expected_q[$];
   logic [30:0]      tolerance;

   function automatic longint clamp32(input longint v, inout bit ov);
      if (v > 64'sd2147483647) begin
         ov = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         ov = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Q16.16 product, floored
   function automatic longint qmul(input longint x, input longint y);
      return (x * y) >>> 16;
   endfunction

   function automatic bit [63:0] square_sum(input longint d0, input longint d1,
                                             input longint d2);
      bit [63:0] u0, u1, u2;
      u0 = d0 < 0 ? -d0 : d0;
      u1 = d1 < 0 ? -d1 : d1;
      u2 = d2 < 0 ? -d2 : d2;
      return ((u0 * u0) >> 16) + ((u1 * u1) >> 16) + ((u2 * u2) >> 16);
   endfunction

   function automatic bit [63:0] int_sqrt(input bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint q_root(input bit [63:0] s, inout bit ov);
      if (s >= 64'd1 << 46) begin
         ov = 1'b1;
         return 64'sd2147483647;
      end
      return longint'(int_sqrt(s << 16));
   endfunction

   function automatic longint clamp_unsigned(input bit [63:0] s, inout bit ov);
      if (s > 64'd2147483647) begin
         ov = 1'b1;
         return 64'sd2147483647;
      end
      return longint'(s);
   endfunction

   function automatic vfa_pkg::rsp_type vector_result(input vfa_pkg::req_type q,
                                                      input logic [30:0] tol);
      longint a[3], b[3], r[3], d[3];
      longint s, sc, rc;
      bit [63:0] sq, m;
      bit ov, cmp;
      vfa_pkg::rsp_type o;
      a[0] = q.ax; a[1] = q.ay; a[2] = q.az;
      b[0] = q.bx; b[1] = q.by; b[2] = q.bz;
      s = q.scale_value;
      r = '{0, 0, 0};
      sc = 0;
      ov = 0;
      cmp = 0;
      for (int i = 0; i < 3; i++) d[i] = a[i] - b[i];
      case (q.func)
         vfa_pkg::FN_ADD:   for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] + b[i], ov);
         vfa_pkg::FN_SUB:   for (int i = 0; i < 3; i++) r[i] = clamp32(d[i], ov);
         vfa_pkg::FN_NEG:   for (int i = 0; i < 3; i++) r[i] = clamp32(-a[i], ov);
         vfa_pkg::FN_SCALE:
            for (int i = 0; i < 3; i++) r[i] = clamp32(qmul(a[i], s), ov);
         vfa_pkg::FN_DIV: begin
            if (s == 0) begin
               ov = 1'b1;
               for (int i = 0; i < 3; i++)
                  r[i] = a[i] > 0 ? 64'sd2147483647 : (a[i] < 0 ? -64'sd2147483648 : 0);
            end else begin
               rc = clamp32(64'sd4294967296 / s, ov);
               for (int i = 0; i < 3; i++) r[i] = clamp32(qmul(a[i], rc), ov);
            end
         end
         vfa_pkg::FN_DOT:
            sc = clamp32(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]), ov);
         vfa_pkg::FN_CROSS: begin
            r[0] = clamp32(qmul(a[1], b[2]) - qmul(b[1], a[2]), ov);
            r[1] = clamp32(qmul(a[2], b[0]) - qmul(b[2], a[0]), ov);
            r[2] = clamp32(qmul(a[0], b[1]) - qmul(b[0], a[1]), ov);
         end
         vfa_pkg::FN_MAGSQ: sc = clamp_unsigned(square_sum(a[0], a[1], a[2]), ov);
         vfa_pkg::FN_MAG:   sc = q_root(square_sum(a[0], a[1], a[2]), ov);
         vfa_pkg::FN_NORM: begin
            sq = square_sum(a[0], a[1], a[2]);
            // a zero length passes A through untouched
            if (sq == 0) begin
               r = a;
            end else begin
               m = int_sqrt(sq << 16);
               rc = longint'(64'd4294967296 / m);
               for (int i = 0; i < 3; i++) r[i] = clamp32(qmul(a[i], rc), ov);
            end
         end
         vfa_pkg::FN_DIST:   sc = q_root(square_sum(d[0], d[1], d[2]), ov);
         vfa_pkg::FN_DISTSQ: sc = clamp_unsigned(square_sum(d[0], d[1], d[2]), ov);
         vfa_pkg::FN_CLOSE: begin
            cmp = 1'b1;
            for (int i = 0; i < 3; i++)
               if ((d[i] < 0 ? -d[i] : d[i]) > longint'(tol)) cmp = 1'b0;
         end
         vfa_pkg::FN_LESS:  cmp = a[0] < b[0] && a[1] < b[1] && a[2] < b[2];
         vfa_pkg::FN_EQUAL: cmp = a[0] == b[0] && a[1] == b[1] && a[2] == b[2];
         default: ;
      endcase
      o.rx = r[0][31:0];
      o.ry = r[1][31:0];
      o.rz = r[2][31:0];
      o.scalar_result = sc[31:0];
      o.compare_flag = cmp;
      o.overflow_flag = ov;
      return o;
   endfunction

   assign in_flight = expected_q.size();

   always @(posedge clock) begin
      vfa_pkg::rsp_type exp_rsp;
      if (reset) begin
         tolerance = vfa_pkg::TOL_RESET;
         mismatches = 0;
         expected_q.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == vfa_pkg::ADDR_TOL)
            tolerance = pwdata[30:0];
         if (req_valid && req_ready)
            expected_q.push_back(vector_result(req_data, tolerance));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               exp_rsp = expected_q.pop_front();
               if (rsp_data.rx !== exp_rsp.rx) begin
                  $error("rx expected %h actual %h", exp_rsp.rx, rsp_data.rx);
                  mismatches++;
               end
               if (rsp_data.ry !== exp_rsp.ry) begin
                  $error("ry expected %h actual %h", exp_rsp.ry, rsp_data.ry);
                  mismatches++;
               end
               if (rsp_data.rz !== exp_rsp.rz) begin
                  $error("rz expected %h actual %h", exp_rsp.rz, rsp_data.rz);
                  mismatches++;
               end
               if (rsp_data.scalar_result !== exp_rsp.scalar_result) begin
                  $error("scalar_result expected %h actual %h",
                         exp_rsp.scalar_result, rsp_data.scalar_result);
                  mismatches++;
               end
               if (rsp_data.compare_flag !== exp_rsp.compare_flag) begin
                  $error("compare_flag expected %b actual %b",
                         exp_rsp.compare_flag, rsp_data.compare_flag);
                  mismatches++;
               end
               if (rsp_data.overflow_flag !== exp_rsp.overflow_flag) begin
                  $error("overflow_flag expected %b actual %b",
                         exp_rsp.overflow_flag, rsp_data.overflow_flag);
                  mismatches++;
               end
            end
         end
      end
   end

endmodule

### tb/vec3_fixed_point_alu_test.sv
`timescale 1ns / 100ps
// Top of the vector ALU testbench: clock, reset, stimulus and verdict.
module vec3_fixed_point_alu_test;

   localparam int PIPE_DEPTH = 69;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   vfa_pkg::req_type  req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   vfa_pkg::rsp_type  rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [1:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;
   int                mismatches;
   int                in_flight;
   bit                hold_long;
   bit                no_idle;

   vec3_fixed_point_alu dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   vec3_fixed_point_alu_check checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .mismatches(mismatches), .in_flight(in_flight)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("FAIL vec3_fixed_point_alu");
      $finish;
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      rsp_ready = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_long) begin
            rsp_ready <= 0;
            repeat (400) @(posedge clock);
            hold_long = 0;
         end
         stall = no_idle ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic write_tolerance(input logic [30:0] tol);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= vfa_pkg::ADDR_TOL;
      pwdata <= {1'b0, tol};
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic send_vector(input vfa_pkg::req_type item);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 1024)) - 512);
         3: return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
         4: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic vfa_pkg::req_type random_vector();
      vfa_pkg::req_type q;
      q.func = 4'($urandom_range(0, 15));
      q.ax = pick_word(); q.ay = pick_word(); q.az = pick_word();
      q.bx = pick_word(); q.by = pick_word(); q.bz = pick_word();
      q.scale_value = pick_word();
      // near-equal operands so closeness and equality see both outcomes
      if ($urandom_range(0, 3) == 0) begin
         q.bx = q.ax + 32'($signed($urandom_range(0, 1400)) - 700);
         q.by = q.ay + 32'($signed($urandom_range(0, 1400)) - 700);
         q.bz = q.az + 32'($signed($urandom_range(0, 1400)) - 700);
         if ($urandom_range(0, 2) == 0) {q.bx, q.by, q.bz} = {q.ax, q.ay, q.az};
      end
      return q;
   endfunction

   function automatic vfa_pkg::req_type make_vector(input logic [3:0] f,
                                           input logic [31:0] ax,
                                           input logic [31:0] ay, input logic [31:0] az,
                                           input logic [31:0] bx, input logic [31:0] by,
                                           input logic [31:0] bz, input logic [31:0] sv);
      vfa_pkg::req_type q;
      q.func = f;
      q.ax = ax; q.ay = ay; q.az = az;
      q.bx = bx; q.by = by; q.bz = bz;
      q.scale_value = sv;
      return q;
   endfunction

   initial begin
      logic [31:0] mx, mn, one;
      vfa_pkg::req_type directed[$];
      mx = 32'h7FFF_FFFF;
      mn = 32'h8000_0000;
      one = 32'h0001_0000;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      hold_long = 0;
      no_idle = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      directed.push_back(make_vector(vfa_pkg::FN_ADD, mx, mn, one, mx, mn, one, 0));
      directed.push_back(make_vector(vfa_pkg::FN_SUB, mn, mx, 0, mx, mn, 0, 0));
      directed.push_back(make_vector(vfa_pkg::FN_NEG, mn, mx, 0, 0, 0, 0, 0));
      directed.push_back(make_vector(vfa_pkg::FN_SCALE, mx, mn, one, 0, 0, 0, mx));
      directed.push_back(make_vector(vfa_pkg::FN_SCALE, 32'hFFFF_FFFF, 3, -3, 0, 0, 0,
                                     32'h0000_8000));
      // divide by zero: positive, negative and zero components
      directed.push_back(make_vector(vfa_pkg::FN_DIV, 5, -5, 0, 0, 0, 0, 0));
      directed.push_back(make_vector(vfa_pkg::FN_DIV, one, -one, 0, 0, 0, 0, 32'hFFFF_FFFF));
      directed.push_back(make_vector(vfa_pkg::FN_DIV, mx, mn, one, 0, 0, 0, 32'h0002_0000));
      directed.push_back(make_vector(vfa_pkg::FN_DIV, one, 7, -9, 0, 0, 0, 1));
      directed.push_back(make_vector(vfa_pkg::FN_DOT, mx, mx, mx, mx, mx, mx, 0));
      directed.push_back(make_vector(vfa_pkg::FN_DOT, -1, 2, -3, 1, 1, 1, 0));
      directed.push_back(make_vector(vfa_pkg::FN_CROSS, mn, mx, one, mx, mn, -one, 0));
      directed.push_back(make_vector(vfa_pkg::FN_MAGSQ, mn, mn, mn, 0, 0, 0, 0));
      directed.push_back(make_vector(vfa_pkg::FN_MAG, mn, mn, mn, 0, 0, 0, 0));
      directed.push_back(make_vector(vfa_pkg::FN_MAG, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_vector(vfa_pkg::FN_NORM, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_vector(vfa_pkg::FN_NORM, 1, -1, 255, 0, 0, 0, 0));
      directed.push_back(make_vector(vfa_pkg::FN_NORM, 256, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_vector(vfa_pkg::FN_NORM, mx, mn, one, 0, 0, 0, 0));
      directed.push_back(make_vector(vfa_pkg::FN_DIST, mx, mx, mx, mn, mn, mn, 0));
      directed.push_back(make_vector(vfa_pkg::FN_DISTSQ, one, 0, 0, 0, one, 0, 0));
      // closeness right at the tolerance and one past it
      directed.push_back(make_vector(vfa_pkg::FN_CLOSE, 655, 0, -655, 0, 655, 0, 0));
      directed.push_back(make_vector(vfa_pkg::FN_CLOSE, 656, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_vector(vfa_pkg::FN_LESS, mn, -1, 0, mx, 0, 1, 0));
      directed.push_back(make_vector(vfa_pkg::FN_EQUAL, mn, mx, 0, mn, mx, 0, 0));
      directed.push_back(make_vector(vfa_pkg::FN_NONE, mx, mn, one, mx, mn, one, mx));
      foreach (directed[i]) send_vector(directed[i]);
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_tolerance(31'd0);
            1: write_tolerance(31'h7FFF_FFFF);
            2: write_tolerance(vfa_pkg::TOL_RESET);
            3: write_tolerance(31'($urandom_range(0, 2000)));
            default: write_tolerance(31'($urandom));
         endcase
         if (phase == 2) begin
            // fill the pipe against a stalled response side
            no_idle = 1;
            hold_long = 1;
            repeat (120) send_vector(random_vector());
            no_idle = 0;
         end
         for (int n = 0; n < 130; n++) begin
            if (n % 40 == 20) no_idle = ~no_idle;
            send_vector(random_vector());
         end
         no_idle = 0;
         drain();
      end

      if (mismatches == 0 && in_flight == 0)
         $display("PASS vec3_fixed_point_alu");
      else
         $display("FAIL vec3_fixed_point_alu");
      $finish;
   end

endmodule
